@@ src/chrs_pkg.sv @@
// Shared types, codes and hash helper for the consistent-hash ring selector.
`timescale 1ns / 1ps
`default_nettype none
package chrs_pkg;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [7:0]  HASH_SEP  = 8'h23;
   localparam logic [7:0]  ASCII_ZERO = 8'h30;

   localparam logic [1:0] MODE_KEY   = 2'd0;
   localparam logic [1:0] MODE_ID    = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
      logic       last;
      logic [5:0] instance_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [5:0]  selected_instance;
      logic [31:0] key_hash;
      logic        ring_empty;
      logic        ring_full;
   } rsp_type;

   typedef struct packed {
      logic [31:0] point_hash;
      logic [5:0]  owner;
   } entry_type;

   // one FNV-1a step, byte sign-extended before the xor
   function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      x = h ^ {{24{b[7]}}, b};
      return 32'(x * FNV_PRIME);
   endfunction

endpackage
`default_nettype wire

@@ src/consistent_hash_ring_selector.sv @@
// Top level: FNV-1a consistent-hash ring with sorted point memory.
`timescale 1ns / 1ps
`default_nettype none
// Requests carry one string byte each; a non-final key or id byte is hashed.
// A lookup does a binary search over the sorted point memory; each probe reads in
// S_BS and compares the registered read data in S_BSW. An insert walks the
// virtual nodes one by one: per node, separator and digit hashing, the binary
// search, and when the point is new and the ring has room a shift of every larger
// entry up by one, all through the single read and single write port of the
// memory. Clear zeroes the point count. Results wait in an output register.
module consistent_hash_ring_selector #(
   parameter int RING_SIZE = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire chrs_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output chrs_pkg::rsp_type       rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [12:0]        csr_wr_data
);
   import chrs_pkg::*;

   localparam int AW = $clog2(RING_SIZE);
   localparam int CW = $clog2(RING_SIZE + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_OUT  = 4'd1;
   localparam logic [3:0] S_BS   = 4'd2;
   localparam logic [3:0] S_BSW  = 4'd3;
   localparam logic [3:0] S_LKW  = 4'd4;
   localparam logic [3:0] S_PH   = 4'd5;
   localparam logic [3:0] S_PD   = 4'd6;
   localparam logic [3:0] S_ICHK = 4'd7;
   localparam logic [3:0] S_SHR  = 4'd8;
   localparam logic [3:0] S_SHW  = 4'd9;
   localparam logic [3:0] S_NEXT = 4'd10;

   entry_type mem [RING_SIZE];
   entry_type rdata_ff;

   logic [3:0]    state_ff, state_in;
   logic [12:0]   vnodes_ff;
   logic [31:0]   hash_ff, hash_in;
   logic [31:0]   key_ff, key_in;
   logic [31:0]   tgt_ff, tgt_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, j_ff, j_in;
   logic          ins_ff, ins_in;
   logic [5:0]    inst_ff, inst_in;
   logic [12:0]   v_ff, v_in;
   logic [15:0]   bcd_ff, bcd_in;
   logic [1:0]    k_ff, k_in;
   logic          drop_ff, drop_in;
   rsp_type       res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   entry_type     mem_wdata;
   logic [31:0]   fold_h, fold_out;
   logic [7:0]    fold_b;
   logic [CW:0]   mid_sum;
   logic [CW-1:0] mid_c;
   logic [CW-1:0] j_dec;
   logic [1:0]    top_digit;
   logic [15:0]   bcd_inc;
   logic          carry;
   logic          accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_c     = mid_sum[CW:1];
   assign j_dec     = j_ff - CW'(1);
   assign fold_out  = fnv_fold(fold_h, fold_b);

   always_comb begin
      top_digit = 2'd0;
      for (int i = 1; i < 4; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            top_digit = 2'(i);
         end
      end
      bcd_inc = bcd_ff;
      carry   = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (carry) begin
            if (bcd_ff[4*i +: 4] == 4'd9) begin
               bcd_inc[4*i +: 4] = 4'd0;
            end else begin
               bcd_inc[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd1;
               carry = 1'b0;
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      key_in       = key_ff;
      tgt_in       = tgt_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      j_in         = j_ff;
      ins_in       = ins_ff;
      inst_in      = inst_ff;
      v_in         = v_ff;
      bcd_in       = bcd_ff;
      k_in         = k_ff;
      drop_in      = drop_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = lo_ff[AW-1:0];
      mem_wdata    = '{point_hash: tgt_ff, owner: inst_ff};
      mem_raddr    = mid_c[AW-1:0];
      fold_h       = hash_ff;
      fold_b       = req_data.data_byte;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.mode == MODE_CLEAR) begin
                  count_in = '0;
                  hash_in  = FNV_BASIS;
                  res_in   = '{result_kind: KIND_CLEAR, selected_instance: 6'd0,
                               key_hash: 32'd0, ring_empty: 1'b0, ring_full: 1'b0};
                  state_in = S_OUT;
               end else if (req_data.mode == MODE_KEY || req_data.mode == MODE_ID) begin
                  if (!req_data.last) begin
                     hash_in = fold_out;
                  end else begin
                     hash_in = FNV_BASIS;
                     key_in  = fold_out;
                     tgt_in  = fold_out;
                     inst_in = req_data.instance_index;
                     ins_in  = (req_data.mode == MODE_ID);
                     lo_in   = '0;
                     hi_in   = count_ff;
                     v_in    = '0;
                     bcd_in  = '0;
                     drop_in = 1'b0;
                     if (req_data.mode == MODE_KEY) begin
                        if (count_ff == '0) begin
                           res_in   = '{result_kind: KIND_LOOKUP, selected_instance: 6'd0,
                                        key_hash: fold_out, ring_empty: 1'b1,
                                        ring_full: 1'b0};
                           state_in = S_OUT;
                        end else begin
                           state_in = S_BS;
                        end
                     end else if (vnodes_ff == 13'd0) begin
                        res_in   = '{result_kind: KIND_INSERT,
                                     selected_instance: req_data.instance_index,
                                     key_hash: fold_out, ring_empty: (count_ff == '0),
                                     ring_full: 1'b0};
                        state_in = S_OUT;
                     end else begin
                        state_in = S_PH;
                     end
                  end
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         S_PH: begin
            fold_h   = key_ff;
            fold_b   = HASH_SEP;
            tgt_in   = fold_out;
            k_in     = top_digit;
            state_in = S_PD;
         end
         S_PD: begin
            fold_h = tgt_ff;
            fold_b = ASCII_ZERO | {4'd0, bcd_ff[4*k_ff +: 4]};
            tgt_in = fold_out;
            if (k_ff == 2'd0) begin
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = S_BS;
            end else begin
               k_in = k_ff - 2'd1;
            end
         end
         S_BS: begin
            if (lo_ff < hi_ff) begin
               mem_raddr = mid_c[AW-1:0];
               mid_in    = mid_c;
               state_in  = S_BSW;
            end else if (!ins_ff) begin
               mem_raddr = (lo_ff >= count_ff) ? '0 : lo_ff[AW-1:0];
               state_in  = S_LKW;
            end else begin
               mem_raddr = lo_ff[AW-1:0];
               state_in  = S_ICHK;
            end
         end
         S_BSW: begin
            if (rdata_ff.point_hash < tgt_ff) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_BS;
         end
         S_LKW: begin
            res_in   = '{result_kind: KIND_LOOKUP, selected_instance: rdata_ff.owner,
                         key_hash: key_ff, ring_empty: 1'b0, ring_full: 1'b0};
            state_in = S_OUT;
         end
         S_ICHK: begin
            if (lo_ff < count_ff && rdata_ff.point_hash == tgt_ff) begin
               mem_we   = 1'b1;
               state_in = S_NEXT;
            end else if (count_ff >= CW'(RING_SIZE)) begin
               drop_in  = 1'b1;
               state_in = S_NEXT;
            end else begin
               j_in     = count_ff;
               state_in = S_SHR;
            end
         end
         S_SHR: begin
            if (j_ff > lo_ff) begin
               mem_raddr = j_dec[AW-1:0];
               state_in  = S_SHW;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = S_NEXT;
            end
         end
         S_SHW: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff[AW-1:0];
            mem_wdata = rdata_ff;
            j_in      = j_dec;
            state_in  = S_SHR;
         end
         S_NEXT: begin
            if ({1'b0, v_ff} + 14'd1 >= {1'b0, vnodes_ff}) begin
               res_in   = '{result_kind: KIND_INSERT, selected_instance: inst_ff,
                            key_hash: key_ff, ring_empty: (count_ff == '0),
                            ring_full: drop_ff};
               state_in = S_OUT;
            end else begin
               v_in     = v_ff + 13'd1;
               bcd_in   = bcd_inc;
               state_in = S_PH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vnodes_ff    <= 13'd100;
         hash_ff      <= FNV_BASIS;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            vnodes_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      tgt_ff      <= tgt_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      j_ff        <= j_in;
      ins_ff      <= ins_in;
      inst_ff     <= inst_in;
      v_ff        <= v_in;
      bcd_ff      <= bcd_in;
      k_ff        <= k_in;
      drop_ff     <= drop_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

@@ dv/consistent_hash_ring_selector_tb.sv @@
// Testbench: random and directed requests against a ring predictor, scoreboarded per field.
`timescale 1ns / 1ps
`default_nettype none
module consistent_hash_ring_selector_tb;
   import chrs_pkg::*;

   localparam int POINT_LIMIT = 4096;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [12:0] csr_wr_data;

   req_type     pending_reqs[$];
   rsp_type     expected_rsps[$];
   entry_type   ring_pts[$];
   logic [31:0] model_hash;
   logic [12:0] model_vnodes;
   int          fail_count;
   int          send_gap;
   int          recv_gap;
   bit          req_taken;
   bit          no_idle;
   int          gen_items;
   int          gen_points;

   consistent_hash_ring_selector i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
      logic [31:0] x;
      x = h ^ {{24{b[7]}}, b};
      return x * 32'd16777619;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // returns 0 when a new point had to be dropped
   function automatic bit add_point(logic [31:0] h, logic [5:0] owner);
      int pos;
      entry_type e;
      pos = 0;
      while (pos < ring_pts.size() && ring_pts[pos].point_hash < h) pos++;
      if (pos < ring_pts.size() && ring_pts[pos].point_hash == h) begin
         ring_pts[pos].owner = owner;
         return 1'b1;
      end
      if (ring_pts.size() >= POINT_LIMIT) return 1'b0;
      e.point_hash = h;
      e.owner = owner;
      ring_pts.insert(pos, e);
      return 1'b1;
   endfunction

   task automatic predict_ring(req_type r);
      rsp_type     exp_rsp;
      logic [31:0] h;
      logic [31:0] p;
      string       digits;
      bit          dropped;
      int          pos;
      exp_rsp = '0;
      if (r.mode == MODE_CLEAR) begin
         ring_pts.delete();
         model_hash = FNV_BASIS;
         exp_rsp.result_kind = KIND_CLEAR;
         expected_rsps.insert(expected_rsps.size(), exp_rsp);
      end else if (r.mode == MODE_KEY || r.mode == MODE_ID) begin
         model_hash = fnv_step(model_hash, r.data_byte);
         if (r.last) begin
            h = model_hash;
            model_hash = FNV_BASIS;
            exp_rsp.key_hash = h;
            if (r.mode == MODE_KEY) begin
               exp_rsp.result_kind = KIND_LOOKUP;
               if (ring_pts.size() == 0) begin
                  exp_rsp.ring_empty = 1'b1;
               end else begin
                  pos = 0;
                  while (pos < ring_pts.size() && ring_pts[pos].point_hash < h) pos++;
                  if (pos >= ring_pts.size()) pos = 0;
                  exp_rsp.selected_instance = ring_pts[pos].owner;
               end
            end else begin
               dropped = 1'b0;
               for (int v = 0; v < model_vnodes; v++) begin
                  digits = $sformatf("%0d", v);
                  p = fnv_step(h, HASH_SEP);
                  for (int k = 0; k < digits.len(); k++) p = fnv_step(p, digits[k]);
                  if (!add_point(p, r.instance_index)) dropped = 1'b1;
               end
               exp_rsp.result_kind = KIND_INSERT;
               exp_rsp.selected_instance = r.instance_index;
               exp_rsp.ring_empty = (ring_pts.size() == 0);
               exp_rsp.ring_full = dropped;
            end
            expected_rsps.insert(expected_rsps.size(), exp_rsp);
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_ring(req_data);
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_gap  = 0;
      end else if (!(req_valid && !req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            send_gap  = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // response side
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  = 0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         recv_gap  = pick_gap();
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response %p", rsp_data);
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.result_kind !== e.result_kind) begin
               $error("result_kind exp %0d got %0d", e.result_kind, rsp_data.result_kind);
               fail_count++;
            end
            if (rsp_data.selected_instance !== e.selected_instance) begin
               $error("selected_instance exp %0d got %0d", e.selected_instance,
                      rsp_data.selected_instance);
               fail_count++;
            end
            if (rsp_data.key_hash !== e.key_hash) begin
               $error("key_hash exp %h got %h", e.key_hash, rsp_data.key_hash);
               fail_count++;
            end
            if (rsp_data.ring_empty !== e.ring_empty) begin
               $error("ring_empty exp %0d got %0d", e.ring_empty, rsp_data.ring_empty);
               fail_count++;
            end
            if (rsp_data.ring_full !== e.ring_full) begin
               $error("ring_full exp %0d got %0d", e.ring_full, rsp_data.ring_full);
               fail_count++;
            end
         end
      end
   end

   task automatic push_req(logic [1:0] mode, logic [7:0] b, logic last, logic [5:0] idx);
      req_type r;
      r.mode = mode;
      r.data_byte = b;
      r.last = last;
      r.instance_index = idx;
      pending_reqs.insert(pending_reqs.size(), r);
      gen_items++;
   endtask

   task automatic push_string(logic [1:0] mode, int len, logic [5:0] idx);
      for (int i = 0; i < len; i++)
         push_req(mode, 8'($urandom), i == len - 1, idx);
      if (mode == MODE_ID) gen_points += model_vnodes;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_vnodes(logic [12:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      model_vnodes = value;
   endtask

   task automatic random_phase(int count, bit lookups_only);
      int r;
      int stop_at;
      stop_at = gen_items + count;
      while (gen_items < stop_at) begin
         r = $urandom_range(0, 99);
         if (gen_points > 200 || r < 5) begin
            push_req(MODE_CLEAR, 8'($urandom), 1'($urandom), 6'($urandom));
            gen_points = 0;
         end else if (r < 60 || lookups_only) begin
            push_string(MODE_KEY, $urandom_range(1, 6), 6'($urandom));
         end else if (r < 85) begin
            push_string(MODE_ID, $urandom_range(1, 6), 6'($urandom));
         end else if (r < 92) begin
            push_req(2'd3, 8'($urandom), 1'($urandom), 6'($urandom));
         end else begin
            // mixed modes in one string
            push_req(MODE_ID, 8'($urandom), 1'b0, 6'($urandom));
            push_string(MODE_KEY, $urandom_range(1, 3), 6'($urandom));
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      fail_count   = 0;
      model_hash   = FNV_BASIS;
      model_vnodes = 13'd100;
      no_idle      = 1'b0;
      gen_items    = 0;
      gen_points   = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty lookup, inserts at default vnodes, byte extremes, noise
      push_req(MODE_KEY, 8'h00, 1'b1, 6'd0);
      push_req(MODE_ID, 8'h61, 1'b1, 6'd63);
      gen_points += 100;
      push_req(MODE_KEY, 8'h00, 1'b1, 6'd0);
      push_req(MODE_KEY, 8'hFF, 1'b1, 6'd63);
      push_req(MODE_KEY, 8'h80, 1'b0, 6'd0);
      push_req(MODE_KEY, 8'h7F, 1'b1, 6'd0);
      push_req(2'd3, 8'hFF, 1'b1, 6'd63);
      push_req(MODE_KEY, 8'h41, 1'b0, 6'd0);
      push_req(MODE_ID, 8'h62, 1'b1, 6'd5);
      gen_points += 100;
      push_req(MODE_ID, 8'h61, 1'b1, 6'd0);
      push_req(MODE_KEY, 8'h31, 1'b0, 6'd0);
      push_req(MODE_CLEAR, 8'hFF, 1'b0, 6'd63);
      push_req(MODE_KEY, 8'h31, 1'b1, 6'd0);
      push_req(MODE_CLEAR, 8'h00, 1'b1, 6'd0);
      gen_points = 0;

      write_vnodes(13'd0);
      push_req(MODE_ID, 8'h61, 1'b1, 6'd7);
      push_req(MODE_KEY, 8'h61, 1'b1, 6'd0);

      write_vnodes(13'd1);
      random_phase(100, 1'b0);
      write_vnodes(13'd8);
      no_idle = 1'b1;
      random_phase(80, 1'b0);
      no_idle = 1'b0;
      write_vnodes(13'd3);
      random_phase(120, 1'b0);
      write_vnodes(13'd16);
      random_phase(120, 1'b0);
      write_vnodes(13'd4096);
      random_phase(30, 1'b1);
      write_vnodes(13'd8191);
      random_phase(20, 1'b1);
      write_vnodes(13'd5);
      random_phase(60, 1'b0);

      drain();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire

@@ consistent_hash_ring_selector.f @@
src/chrs_pkg.sv
src/consistent_hash_ring_selector.sv
dv/consistent_hash_ring_selector_tb.sv
